[rtl/core/kpl_pkg.sv]
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and constants for the keypad pin lock with lockout.
// ----------------------------------------------------------------------------
package kpl_pkg;

  localparam int PIN_DIGITS = 4;
  localparam int DIGIT_W    = 4;
  localparam int POS_W      = 3;
  localparam int ENTRY_W    = PIN_DIGITS * DIGIT_W;
  localparam int PIN_W      = 16;
  localparam int CMP_W      = (ENTRY_W > PIN_W) ? ENTRY_W : PIN_W;
  localparam int CNT_W      = $clog2(PIN_DIGITS + 1);
  localparam int DIG_IDX_W  = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int TIME_W     = 32;
  localparam int FAIL_W     = 8;
  localparam int MAXF_W     = 4;
  localparam int SEC_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // button codes
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_UP     = 2'd1;
  localparam logic [1:0] BTN_DOWN   = 2'd2;
  localparam logic [1:0] BTN_SELECT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STORED_PIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_PIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_PENDING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LOCKOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_STEP    = 3'd5;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 4'd9;
  localparam logic [FAIL_W-1:0]  FAIL_SAT       = 8'd255;
  localparam logic [MAXF_W-1:0]  MAXF_RESET     = 4'd3;
  localparam logic [TIME_W-1:0]  LOCKOUT_RESET  = 32'd30000;

  // x / 1000 for any 32-bit x: (x * ceil(2^38 / 1000)) >> 38
  localparam int RECIP_W  = 29;
  localparam int DIV_SH   = 38;
  localparam int PROD_W   = TIME_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MS_RECIP = 29'd274877907;

  // word handed from the front end to the back end
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               done;
    logic [ENTRY_W-1:0] entry;
    logic [TIME_W-1:0]  now_ms;
  } kpl_word_t;

endpackage

[rtl/core/kpl_front.sv]
// ----------------------------------------------------------------------------
// kpl_front
// Accepts button words, steps the digit and cursor, packs completed entries.
// ----------------------------------------------------------------------------
module kpl_front import kpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_button,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              q_full,
  output logic              push_valid,
  output kpl_word_t         push_word
);

  logic [DIGIT_W-1:0] digit_reg_r, digit_reg_nxt;
  logic [CNT_W-1:0]   digit_count_r, digit_count_nxt;
  logic [DIGIT_W-1:0] entered_r [PIN_DIGITS];
  logic               accept;
  logic               is_select;
  logic [CNT_W-1:0]   count_inc;
  logic               done;
  logic [DIGIT_W-1:0] shown_digit;
  logic [ENTRY_W-1:0] entry;

  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign is_select = (in_button == BTN_SELECT);
  assign count_inc = digit_count_r + CNT_W'(1);
  assign done      = is_select && (count_inc == CNT_W'(PIN_DIGITS));

  always_comb begin
    shown_digit = digit_reg_r;
    case (in_button)
      BTN_UP:     shown_digit = (digit_reg_r == DIGIT_MAX) ? '0 : digit_reg_r + 4'd1;
      BTN_DOWN:   shown_digit = (digit_reg_r == '0) ? DIGIT_MAX : digit_reg_r - 4'd1;
      BTN_SELECT: shown_digit = digit_reg_r;
      BTN_NONE:   shown_digit = digit_reg_r;
      default:    shown_digit = digit_reg_r;
    endcase
  end

  // first digit in the top nibble, the last one is the digit being selected now
  always_comb begin
    entry = '0;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      if (i == PIN_DIGITS - 1) begin
        entry[ENTRY_W-1-DIGIT_W*i -: DIGIT_W] = digit_reg_r;
      end else begin
        entry[ENTRY_W-1-DIGIT_W*i -: DIGIT_W] = entered_r[i];
      end
    end
  end

  always_comb begin
    digit_reg_nxt   = digit_reg_r;
    digit_count_nxt = digit_count_r;
    if (accept) begin
      digit_reg_nxt = shown_digit;
      if (is_select) begin
        digit_count_nxt = count_inc;
      end
      if (done) begin
        digit_reg_nxt   = '0;
        digit_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_reg_r   <= '0;
      digit_count_r <= '0;
    end else begin
      digit_reg_r   <= digit_reg_nxt;
      digit_count_r <= digit_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_select) begin
      entered_r[digit_count_r[DIG_IDX_W-1:0]] <= digit_reg_r;
    end
  end

  assign push_valid       = accept;
  assign push_word.digit  = shown_digit;
  assign push_word.pos    = is_select ? POS_W'(count_inc) : POS_W'(digit_count_r);
  assign push_word.done   = done;
  assign push_word.entry  = entry;
  assign push_word.now_ms = in_now_ms;

endmodule

[rtl/core/kpl_queue.sv]
// ----------------------------------------------------------------------------
// kpl_queue
// Short word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kpl_queue import kpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  kpl_word_t push_word,
  output logic      full,
  output logic      pop_valid,
  input  logic      pop_ready,
  output kpl_word_t pop_word
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  kpl_word_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               push, pop;

  assign full      = (count_r == CNT_QW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid & ~full;
  assign pop       = pop_valid & pop_ready;
  assign pop_word  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_QW'(1);
      2'b01:   count_nxt = count_r - CNT_QW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[rtl/core/kpl_back.sv]
// ----------------------------------------------------------------------------
// kpl_back
// Compares entries, keeps the failure count and lockout duration, drives results.
// ----------------------------------------------------------------------------
module kpl_back import kpl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  kpl_word_t             q_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_W-1:0]    out_digit_value,
  output logic [POS_W-1:0]      out_digit_position,
  output logic                  out_entry_done,
  output logic                  out_pin_match,
  output logic [FAIL_W-1:0]     out_failed_attempts,
  output logic                  out_lockout_started,
  output logic [TIME_W-1:0]     out_lockout_until_ms,
  output logic [SEC_W-1:0]      out_lockout_seconds
);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               done;
    logic               match;
    logic [FAIL_W-1:0]  failed;
    logic               started;
    logic [TIME_W-1:0]  until_ms;
    logic [TIME_W-1:0]  length;
  } kpl_res_t;

  // configuration
  logic [PIN_W-1:0]  stored_pin_r, pending_pin_r;
  logic              compare_pending_r;
  logic [MAXF_W-1:0] max_failures_r;
  logic [TIME_W-1:0] lockout_step_r;

  logic [FAIL_W-1:0] failure_count_r, failure_count_nxt;
  logic [TIME_W-1:0] lockout_length_r, lockout_length_nxt;

  kpl_res_t          s1_r, s1_nxt;
  logic              s1_valid_r;
  logic              s1_take, s2_load;
  logic              out_valid_r;

  logic [PIN_W-1:0]  ref_pin;
  logic              match;
  logic [FAIL_W-1:0] fail_inc;
  logic              lock;
  logic [TIME_W:0]   len_sum;
  logic [TIME_W-1:0] len_grown;
  logic [PROD_W-1:0] prod;

  assign s2_load = ~out_valid_r | ~out_stall;
  assign s1_take = ~s1_valid_r | s2_load;
  assign q_pop   = q_valid & s1_take;

  assign ref_pin   = compare_pending_r ? pending_pin_r : stored_pin_r;
  assign match     = (CMP_W'(q_word.entry) == CMP_W'(ref_pin));
  assign fail_inc  = (failure_count_r == FAIL_SAT) ? failure_count_r
                                                   : failure_count_r + 8'd1;
  assign lock      = (fail_inc >= FAIL_W'(max_failures_r));
  assign len_sum   = {1'b0, lockout_length_r} + {1'b0, lockout_step_r};
  assign len_grown = len_sum[TIME_W] ? '1 : len_sum[TIME_W-1:0];

  always_comb begin
    failure_count_nxt  = failure_count_r;
    lockout_length_nxt = lockout_length_r;
    s1_nxt.digit    = q_word.digit;
    s1_nxt.pos      = q_word.pos;
    s1_nxt.done     = q_word.done;
    s1_nxt.match    = 1'b0;
    s1_nxt.started  = 1'b0;
    s1_nxt.until_ms = '0;
    if (q_word.done) begin
      if (match) begin
        s1_nxt.match      = 1'b1;
        failure_count_nxt = '0;
      end else begin
        failure_count_nxt = fail_inc;
        if (lock) begin
          s1_nxt.started     = 1'b1;
          s1_nxt.until_ms    = q_word.now_ms + lockout_length_r;
          lockout_length_nxt = len_grown;
        end
      end
    end
    s1_nxt.failed = failure_count_nxt;
    s1_nxt.length = lockout_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_pin_r      <= '0;
      pending_pin_r     <= '0;
      compare_pending_r <= 1'b0;
      max_failures_r    <= MAXF_RESET;
      lockout_step_r    <= LOCKOUT_RESET;
      failure_count_r   <= '0;
      lockout_length_r  <= LOCKOUT_RESET;
    end else begin
      if (q_pop) begin
        failure_count_r  <= failure_count_nxt;
        lockout_length_r <= lockout_length_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STORED_PIN:      stored_pin_r      <= cfg_wdata[PIN_W-1:0];
          CFG_PENDING_PIN:     pending_pin_r     <= cfg_wdata[PIN_W-1:0];
          CFG_COMPARE_PENDING: compare_pending_r <= cfg_wdata[0];
          CFG_MAX_FAILURES:    max_failures_r    <= cfg_wdata[MAXF_W-1:0];
          // the initial duration only ever seeds the running duration
          CFG_INITIAL_LOCKOUT: lockout_length_r  <= cfg_wdata[TIME_W-1:0];
          CFG_LOCKOUT_STEP:    lockout_step_r    <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // stage one holds the decision, stage two the output word with the seconds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= q_valid;
      end
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= s1_nxt;
    end
  end

  assign prod = PROD_W'(s1_r.length) * PROD_W'(MS_RECIP);

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_digit_value      <= s1_r.digit;
      out_digit_position   <= s1_r.pos;
      out_entry_done       <= s1_r.done;
      out_pin_match        <= s1_r.match;
      out_failed_attempts  <= s1_r.failed;
      out_lockout_started  <= s1_r.started;
      out_lockout_until_ms <= s1_r.until_ms;
      out_lockout_seconds  <= prod[DIV_SH +: SEC_W];
    end
  end

  assign out_valid = out_valid_r;

  a_start_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.started) |-> (s1_r.done && !s1_r.match))
    else $error("lockout started without a missed entry");

  a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.match) |-> (s1_r.failed == '0))
    else $error("match left a nonzero failure count");

  a_no_until_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_r.started) |-> (s1_r.until_ms == '0))
    else $error("lockout end time without a lockout");

  a_len_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !cfg_we) |=> (lockout_length_r >= $past(lockout_length_r)))
    else $error("lockout duration shrank");

endmodule

[rtl/core/keypad_pin_lock_with_lockout.sv]
// ----------------------------------------------------------------------------
// keypad_pin_lock_with_lockout
// Button driven PIN entry with failure counting and growing lockout duration.
// ----------------------------------------------------------------------------
// path: an accepted button word is written into the queue, then registered in stage one, then in the output stage
// throughput: one word per cycle; the front end stalls only when its 4-word queue fills
// the seconds figure comes from a 32x29 reciprocal multiply in the last stage
// reset: synchronous active low, clears queue, pipeline, digit and failure state,
// loads configuration defaults and a 30000 ms lockout duration; no clearing pass
module keypad_pin_lock_with_lockout import kpl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_button,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_W-1:0]    out_digit_value,
  output logic [POS_W-1:0]      out_digit_position,
  output logic                  out_entry_done,
  output logic                  out_pin_match,
  output logic [FAIL_W-1:0]     out_failed_attempts,
  output logic                  out_lockout_started,
  output logic [TIME_W-1:0]     out_lockout_until_ms,
  output logic [SEC_W-1:0]      out_lockout_seconds
);

  logic      q_full;
  logic      push_valid;
  kpl_word_t push_word;
  logic      q_valid;
  logic      q_pop;
  kpl_word_t q_word;

  kpl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_button  (in_button),
    .in_now_ms  (in_now_ms),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_word  (push_word)
  );

  kpl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_word   (q_word)
  );

  kpl_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .q_valid              (q_valid),
    .q_pop                (q_pop),
    .q_word               (q_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digit_value      (out_digit_value),
    .out_digit_position   (out_digit_position),
    .out_entry_done       (out_entry_done),
    .out_pin_match        (out_pin_match),
    .out_failed_attempts  (out_failed_attempts),
    .out_lockout_started  (out_lockout_started),
    .out_lockout_until_ms (out_lockout_until_ms),
    .out_lockout_seconds  (out_lockout_seconds)
  );

endmodule
